@@ rtl/core/stq_pkg.sv @@
// Shared constants and types of the sorted timer queue.
`timescale 1ns / 1ps

package stq_pkg;

  localparam int DEPTH        = 16;
  localparam int HANDLER_BITS = 16;
  localparam int TIME_BITS    = 48;
  localparam int CNT_BITS     = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_REPLACE = 2'd0,
    OP_PUSH         = 2'd1,
    OP_ERASE        = 2'd2,
    OP_POP          = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [HANDLER_BITS-1:0] handler;
    logic [TIME_BITS-1:0]    expiry;
  } entry_t;

  typedef struct packed {
    cmd_e   cmd;
    entry_t entry;
  } cell_cmd_t;

endpackage

@@ rtl/core/stq_cell.sv @@
// One slot of the sorted queue: holds an entry and shifts left or right.
`timescale 1ns / 1ps

module stq_cell (
  input  logic              clk_i,
  input  stq_pkg::cell_cmd_t cmd_i,
  input  logic              occupied_i,
  input  logic              found_i,
  input  logic              lt_left_i,
  input  stq_pkg::entry_t   left_i,
  input  stq_pkg::entry_t   right_i,
  output logic              found_o,
  output logic              lt_o,
  output stq_pkg::entry_t   entry_o
);
  import stq_pkg::*;

  entry_t entry_q, entry_d;
  logic   hit;

  always_comb begin
    hit = 1'b0;
    unique case (cmd_i.cmd)
      CMD_REMOVE: hit = occupied_i && !found_i && (entry_q.handler == cmd_i.entry.handler);
      CMD_POP:    hit = occupied_i && !found_i;
      CMD_HOLD,
      CMD_INSERT: hit = 1'b0;
      default:    hit = 1'b0;
    endcase
  end

  // everything at or behind the removed slot moves one place towards the head
  assign found_o = found_i | hit;
  assign lt_o    = occupied_i && (entry_q.expiry < cmd_i.entry.expiry);

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.cmd)
      CMD_REMOVE,
      CMD_POP: begin
        if (found_o) entry_d = right_i;
      end
      CMD_INSERT: begin
        if (!lt_o) entry_d = lt_left_i ? cmd_i.entry : left_i;
      end
      CMD_HOLD: entry_d = entry_q;
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/core/sorted_timer_queue.sv @@
// Sorted timer queue: an input transfer passes the exec and report states before
// output valid; a push with replace that inserts also passes insert (remove pass,
// then insert pass over the cell row). Items are taken only while idle; one item is in
// the cell row while the previous result may wait in the output register.
// The row of cells compares and shifts all slots in parallel, one pass per cycle.
// Reset clears the occupancy and the control state; slot contents are left as they are.
`timescale 1ns / 1ps

module sorted_timer_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       opcode_i,
  input  logic [stq_pkg::HANDLER_BITS-1:0] handler_id_i,
  input  logic [stq_pkg::TIME_BITS-1:0]    expiry_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       status_o,
  output logic [stq_pkg::HANDLER_BITS-1:0] out_handler_o,
  output logic [stq_pkg::TIME_BITS-1:0]    out_expiry_o,
  output logic                             earliest_valid_o,
  output logic [stq_pkg::TIME_BITS-1:0]    earliest_time_o,
  output logic [stq_pkg::CNT_BITS-1:0]     occupancy_o
);
  import stq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INSERT,
    S_REPORT
  } state_e;

  state_e                  state_q;
  opcode_e                 op_q;
  logic [HANDLER_BITS-1:0] handler_q;
  logic [TIME_BITS-1:0]    expiry_q;
  logic [CNT_BITS-1:0]     count_q;
  status_e                 status_q;
  logic [HANDLER_BITS-1:0] pop_handler_q;
  logic [TIME_BITS-1:0]    pop_expiry_q;
  logic                    out_valid_q;
  logic [2:0]              out_status_q;
  logic [HANDLER_BITS-1:0] out_handler_q;
  logic [TIME_BITS-1:0]    out_expiry_q;
  logic                    out_earliest_valid_q;
  logic [TIME_BITS-1:0]    out_earliest_time_q;
  logic [CNT_BITS-1:0]     out_occupancy_q;

  cell_cmd_t          cmd;
  logic [DEPTH:0]     found_chain;
  logic [DEPTH:0]     lt_chain;
  logic [DEPTH-1:0]   occupied;
  entry_t             entries [DEPTH];
  logic               full;
  logic               empty;
  logic               found;

  assign full  = (count_q == CNT_BITS'(DEPTH));
  assign empty = (count_q == '0);
  assign found = found_chain[DEPTH];

  always_comb begin
    cmd.cmd           = CMD_HOLD;
    cmd.entry.handler = handler_q;
    cmd.entry.expiry  = expiry_q;
    unique case (state_q)
      S_EXEC: begin
        unique case (op_q)
          OP_PUSH_REPLACE,
          OP_ERASE: cmd.cmd = CMD_REMOVE;
          OP_PUSH:  if (!full) cmd.cmd = CMD_INSERT;
          OP_POP:   if (!empty) cmd.cmd = CMD_POP;
          default:  cmd.cmd = CMD_HOLD;
        endcase
      end
      S_INSERT: cmd.cmd = CMD_INSERT;
      S_IDLE,
      S_REPORT: cmd.cmd = CMD_HOLD;
      default:  cmd.cmd = CMD_HOLD;
    endcase
  end

  assign found_chain[0] = 1'b0;
  assign lt_chain[0]    = 1'b1;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left, right;

    assign occupied[g] = (count_q > CNT_BITS'(g));

    if (g == 0) begin : g_head
      assign left = cmd.entry;
    end else begin : g_mid
      assign left = entries[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right = entries[g];
    end else begin : g_body
      assign right = entries[g+1];
    end

    stq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (occupied[g]),
      .found_i    (found_chain[g]),
      .lt_left_i  (lt_chain[g]),
      .left_i     (left),
      .right_i    (right),
      .found_o    (found_chain[g+1]),
      .lt_o       (lt_chain[g+1]),
      .entry_o    (entries[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= S_IDLE;
      op_q                 <= OP_PUSH_REPLACE;
      handler_q            <= '0;
      expiry_q             <= '0;
      count_q              <= '0;
      status_q             <= ST_OK;
      pop_handler_q        <= '0;
      pop_expiry_q         <= '0;
      out_valid_q          <= 1'b0;
      out_status_q         <= '0;
      out_handler_q        <= '0;
      out_expiry_q         <= '0;
      out_earliest_valid_q <= 1'b0;
      out_earliest_time_q  <= '0;
      out_occupancy_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_REPORT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q      <= opcode_e'(opcode_i);
            handler_q <= handler_id_i;
            expiry_q  <= expiry_time_i;
            state_q   <= S_EXEC;
          end
        end
        S_EXEC: begin
          // capture the head only for a pop that finds an entry
          pop_handler_q <= (op_q == OP_POP && !empty) ? entries[0].handler : '0;
          pop_expiry_q  <= (op_q == OP_POP && !empty) ? entries[0].expiry : '0;
          unique case (op_q)
            OP_PUSH_REPLACE: begin
              if (found) begin
                count_q  <= count_q - CNT_BITS'(1);
                status_q <= ST_REPLACED;
                state_q  <= S_INSERT;
              end else if (full) begin
                status_q <= ST_FULL;
                state_q  <= S_REPORT;
              end else begin
                status_q <= ST_OK;
                state_q  <= S_INSERT;
              end
            end
            OP_PUSH: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_OK;
                count_q  <= count_q + CNT_BITS'(1);
              end
              state_q <= S_REPORT;
            end
            OP_ERASE: begin
              if (found) begin
                status_q <= ST_OK;
                count_q  <= count_q - CNT_BITS'(1);
              end else begin
                status_q <= ST_NOT_FOUND;
              end
              state_q <= S_REPORT;
            end
            OP_POP: begin
              if (empty) begin
                status_q <= ST_EMPTY;
              end else begin
                status_q <= ST_OK;
                count_q  <= count_q - CNT_BITS'(1);
              end
              state_q <= S_REPORT;
            end
            default: state_q <= S_REPORT;
          endcase
        end
        S_INSERT: begin
          count_q <= count_q + CNT_BITS'(1);
          state_q <= S_REPORT;
        end
        S_REPORT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_status_q         <= status_q;
            out_handler_q        <= pop_handler_q;
            out_expiry_q         <= pop_expiry_q;
            out_earliest_valid_q <= !empty;
            out_earliest_time_q  <= empty ? '0 : entries[0].expiry;
            out_occupancy_q      <= count_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign out_handler_o    = out_handler_q;
  assign out_expiry_o     = out_expiry_q;
  assign earliest_valid_o = out_earliest_valid_q;
  assign earliest_time_o  = out_earliest_time_q;
  assign occupancy_o      = out_occupancy_q;

endmodule
